[src/gbvg_pkg.sv]
// ----------------------------------------------------------------------------
// Gyro bias window package
// Shared widths, reset values and types for the variance gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbvg_pkg;

    localparam int AXES               = 3;
    localparam int SAMPLE_W           = 16;
    localparam int STORE_W            = AXES * SAMPLE_W;
    localparam int IN_TDATA_W         = STORE_W;
    localparam int MEAN_W             = 23;
    localparam int VAR_W              = 31;
    localparam int GATE_W             = 31;
    localparam int OUT_FIELDS_W       = AXES * (MEAN_W + VAR_W);
    localparam int OUT_TDATA_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W        = 2;
    localparam int WINDOW_SAMPLES_DEF = 128;

    localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(4000);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [MEAN_W-1:0]          t_mean;
    typedef logic [VAR_W-1:0]           t_var;

endpackage

`default_nettype wire

[src/gbvg_sample_store.sv]
// ----------------------------------------------------------------------------
// Gyro bias sample store
// Circular window memory, one write and one read-first read per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbvg_sample_store #(
    parameter int DEPTH = gbvg_pkg::WINDOW_SAMPLES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_addr,
    input  wire logic [gbvg_pkg::STORE_W-1:0] i_wr_data,
    output logic      [gbvg_pkg::STORE_W-1:0] o_rd_data
);
    import gbvg_pkg::*;

    logic [STORE_W-1:0] r_mem [DEPTH];

    // read the oldest entry, then overwrite it
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            o_rd_data     <= r_mem[i_addr];
            r_mem[i_addr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

[src/gyro_bias_window_variance_gate.sv]
// ----------------------------------------------------------------------------
// Gyro bias window variance gate
// Sliding-window sums and sums of squares per axis, window variance and gate.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle without output stall; the sliding sum registers take one update
// per request and the sample store has one write/read port per cycle.
// Reset: synchronous active-low; clears pipeline valids, sums, pointers, fill
// count and loads the default gate. The sample store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gyro_bias_window_variance_gate #(
    parameter int WINDOW_SAMPLES = gbvg_pkg::WINDOW_SAMPLES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [gbvg_pkg::GATE_W-1:0]      i_cfg_wr_data,
    // sample requests
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: sample_x, sample_y, sample_z
    input  wire logic [gbvg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // results
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: mean_x, mean_y, mean_z, var_x, var_y, var_z, zero fill
    output logic [gbvg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: bias_found, window_full
    output logic [gbvg_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
    import gbvg_pkg::*;

    localparam int L      = $clog2(WINDOW_SAMPLES);
    localparam int SQ1_W  = 2 * SAMPLE_W - 1;
    localparam int SUM_W  = SAMPLE_W + L;
    localparam int SQ_W   = SQ1_W + L;
    localparam int PROD_W = 2 * SUM_W;
    localparam int CMP_W  = PROD_W - L;
    localparam int EXT_W  = (SUM_W > MEAN_W) ? SUM_W : MEAN_W;
    localparam int STAGES = 6;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] adv;

    logic [GATE_W-1:0] r_gate;
    logic [L-1:0]      r_ptr;
    logic              r_primed;
    logic [L-1:0]      r_fill;

    logic [STORE_W-1:0] rd_data;

    t_sample                  r_s0_smp  [AXES];
    logic                     r_s0_prim;
    t_sample                  old_smp   [AXES];
    logic signed [2*SAMPLE_W-1:0] sq_new [AXES];
    logic signed [2*SAMPLE_W-1:0] sq_old [AXES];

    t_sample                  r_s1_new  [AXES];
    t_sample                  r_s1_old  [AXES];
    logic [SQ1_W-1:0]         r_s1_sqn  [AXES];
    logic [SQ1_W-1:0]         r_s1_sqo  [AXES];

    logic signed [SUM_W-1:0]  r_sum     [AXES];
    logic [SQ_W-1:0]          r_sumsq   [AXES];

    logic signed [PROD_W-1:0] r_s3_prod  [AXES];
    logic [SQ_W-1:0]          r_s3_sumsq [AXES];
    logic signed [SUM_W-1:0]  r_s3_sum   [AXES];

    logic [CMP_W-1:0]         corr      [AXES];
    logic [CMP_W-1:0]         sumsq_e   [AXES];
    logic [CMP_W-1:0]         diff      [AXES];
    logic signed [EXT_W-1:0]  sum_ext   [AXES];

    t_var                     r_s4_var  [AXES];
    t_mean                    r_s4_mean [AXES];

    logic                     full;
    logic                     over;
    logic [OUT_TDATA_W-1:0]   n_tdata;
    logic [OUT_TDATA_W-1:0]   r_tdata;
    logic [OUT_TUSER_W-1:0]   r_tuser;

    // stage handshake
    always_comb begin
        rdy[STAGES-1] = !r_vld[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        adv[0] = rdy[0] && s_axis_tvalid;
        for (int k = 1; k < STAGES; k++) begin
            adv[k] = rdy[k] && r_vld[k-1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;

    gbvg_sample_store #(
        .DEPTH     (WINDOW_SAMPLES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (adv[0]),
        .i_addr    (r_ptr),
        .i_wr_data (s_axis_tdata),
        .o_rd_data (rd_data)
    );

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            old_smp[a] = r_s0_prim ? $signed(rd_data[a*SAMPLE_W +: SAMPLE_W]) : '0;
            sq_new[a]  = r_s0_smp[a] * r_s0_smp[a];
            sq_old[a]  = old_smp[a] * old_smp[a];
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            corr[a]    = r_s3_prod[a][PROD_W-1:L];
            sumsq_e[a] = CMP_W'(r_s3_sumsq[a]);
            diff[a]    = (sumsq_e[a] >= corr[a]) ? (sumsq_e[a] - corr[a]) : '0;
            sum_ext[a] = EXT_W'(r_s3_sum[a]);
        end
    end

    always_comb begin
        full = &r_fill;
        over = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            if (r_s4_var[a] > r_gate) begin
                over = 1'b1;
            end
        end
        n_tdata = '0;
        for (int a = 0; a < AXES; a++) begin
            n_tdata[a*MEAN_W +: MEAN_W] = full ? r_s4_mean[a] : '0;
            n_tdata[AXES*MEAN_W + a*VAR_W +: VAR_W] = full ? r_s4_var[a] : '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_gate   <= GATE_RESET;
            r_ptr    <= '0;
            r_primed <= 1'b0;
            r_fill   <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a]   <= '0;
                r_sumsq[a] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_gate <= i_cfg_wr_data;
            end
            if (rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (adv[0]) begin
                r_ptr <= r_ptr + 1'b1;
                if (&r_ptr) begin
                    r_primed <= 1'b1;
                end
            end
            if (adv[2]) begin
                for (int a = 0; a < AXES; a++) begin
                    r_sum[a]   <= r_sum[a] + SUM_W'(r_s1_new[a]) - SUM_W'(r_s1_old[a]);
                    r_sumsq[a] <= r_sumsq[a] + SQ_W'(r_s1_sqn[a]) - SQ_W'(r_s1_sqo[a]);
                end
            end
            if (adv[5]) begin
                if (full) begin
                    if (over) begin
                        r_fill <= '0;
                    end
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int a = 0; a < AXES; a++) begin
                r_s0_smp[a] <= $signed(s_axis_tdata[a*SAMPLE_W +: SAMPLE_W]);
            end
            r_s0_prim <= r_primed;
        end
        if (adv[1]) begin
            for (int a = 0; a < AXES; a++) begin
                r_s1_new[a] <= r_s0_smp[a];
                r_s1_old[a] <= old_smp[a];
                r_s1_sqn[a] <= sq_new[a][SQ1_W-1:0];
                r_s1_sqo[a] <= sq_old[a][SQ1_W-1:0];
            end
        end
        if (adv[3]) begin
            for (int a = 0; a < AXES; a++) begin
                r_s3_prod[a]  <= r_sum[a] * r_sum[a];
                r_s3_sumsq[a] <= r_sumsq[a];
                r_s3_sum[a]   <= r_sum[a];
            end
        end
        if (adv[4]) begin
            for (int a = 0; a < AXES; a++) begin
                r_s4_var[a]  <= diff[a][L +: VAR_W];
                r_s4_mean[a] <= sum_ext[a][MEAN_W-1:0];
            end
        end
        if (adv[5]) begin
            r_tdata <= n_tdata;
            r_tuser <= {full, full && !over};
        end
    end

endmodule

`default_nettype wire

[dv/gyro_bias_window_variance_gate_tb.sv]
// ----------------------------------------------------------------------------
// Gyro bias window variance gate testbench
// Streams three-axis gyro samples into the gate and follows the sliding window
// alongside it: per-axis sums, sums of squares, variances and the bias gate.
// Every result is compared field by field against the tracked window, while
// both stream sides idle at random and the result side is held off for a
// long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gyro_bias_window_variance_gate_tb;

    import gbvg_pkg::*;

    localparam int WINDOW       = WINDOW_SAMPLES_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic                         bias_found;
        logic                         window_full;
        logic [AXES-1:0][MEAN_W-1:0]  mean;
        logic [AXES-1:0][VAR_W-1:0]   variance;
    } t_window_stats;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_wr_en   = 1'b0;
    logic [GATE_W-1:0]       i_cfg_wr_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata: sample_x, sample_y, sample_z
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata: mean_x, mean_y, mean_z, var_x, var_y, var_z, zero fill
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // tuser: bias_found, window_full
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;

    t_sample           win_store [WINDOW][AXES];
    int                wr_slot    = 0;
    logic              win_full   = 1'b0;
    longint            win_sum   [AXES] = '{0, 0, 0};
    longint            win_sqsum [AXES] = '{0, 0, 0};
    logic [GATE_W-1:0] gate_model = GATE_RESET;

    t_window_stats pending_stats [$];
    int            n_requests  = 0;
    int            n_results   = 0;
    int            n_errors    = 0;
    int            cycle_count = 0;
    int            rx_hold     = 0;
    bit            idle_en     = 1'b1;

    gyro_bias_window_variance_gate #(
        .WINDOW_SAMPLES(WINDOW)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Slide the window by one sample and evaluate it once full.
    function automatic t_window_stats step_window(input logic [IN_TDATA_W-1:0] req);
        t_window_stats r;
        t_sample       smp;
        longint        s;
        longint        old;
        longint        corr;
        longint        diff;
        longint        v;
        logic          pass;
        int            a;
        r    = '0;
        pass = 1'b1;
        for (a = 0; a < AXES; a++) begin
            smp = req[a*SAMPLE_W +: SAMPLE_W];
            s   = smp;
            if (win_full) begin
                old          = win_store[wr_slot][a];
                win_sum[a]   = win_sum[a] - old;
                win_sqsum[a] = win_sqsum[a] - old * old;
            end
            win_sum[a]            = win_sum[a] + s;
            win_sqsum[a]          = win_sqsum[a] + s * s;
            win_store[wr_slot][a] = smp;
        end
        if (wr_slot == WINDOW - 1) begin
            wr_slot  = 0;
            win_full = 1'b1;
        end else begin
            wr_slot = wr_slot + 1;
        end
        if (!win_full)
            return r;
        for (a = 0; a < AXES; a++) begin
            s    = win_sum[a];
            corr = (s * s) / WINDOW;
            diff = (win_sqsum[a] >= corr) ? win_sqsum[a] - corr : 0;
            v    = diff / WINDOW;
            if (v > longint'(gate_model))
                pass = 1'b0;
            r.mean[a]     = s[MEAN_W-1:0];
            r.variance[a] = v[VAR_W-1:0];
        end
        r.bias_found  = pass;
        r.window_full = 1'b1;
        // drop the rejected window and refill from entry 0
        if (!pass) begin
            wr_slot  = 0;
            win_full = 1'b0;
            for (a = 0; a < AXES; a++) begin
                win_sum[a]   = 0;
                win_sqsum[a] = 0;
            end
        end
        return r;
    endfunction

    function automatic t_sample rand_sample();
        logic [31:0] r;
        r = $urandom;
        return r[SAMPLE_W-1:0];
    endfunction

    function automatic t_sample near(input int center, input int amp);
        int v;
        v = center + int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic t_sample edge_value(input int k);
        case (k % 6)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h5555;
            default: return 16'hAAAA;
        endcase
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("result %0d %s: expected %0h got %0h", n_results, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_window_stats want;
        int            a;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                pending_stats.push_back(step_window(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (pending_stats.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("result %0d arrived with nothing pending", n_results);
                end else begin
                    want = pending_stats.pop_front();
                    check_field("bias_found", want.bias_found, m_axis_tuser[0]);
                    check_field("window_full", want.window_full, m_axis_tuser[1]);
                    for (a = 0; a < AXES; a++) begin
                        check_field($sformatf("mean[%0d]", a), want.mean[a],
                                    m_axis_tdata[a*MEAN_W +: MEAN_W]);
                        check_field($sformatf("var[%0d]", a), want.variance[a],
                                    m_axis_tdata[AXES*MEAN_W + a*VAR_W +: VAR_W]);
                    end
                end
            end
        end
    end

    initial begin : result_sink
        int rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready && idle_en)
                rx_wait = $urandom_range(0, 3);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Hold valid across back-to-back requests; lower it only for a gap.
    task automatic send_sample(input t_sample sx, input t_sample sy, input t_sample sz);
        int gap;
        gap = idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sz, sy, sx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_requests++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (n_results < n_requests) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gate(input logic [GATE_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gate_model = value;
    endtask

    task automatic test_filling_extremes();
        int k;
        for (k = 0; k < 20; k++)
            send_sample(edge_value(k), edge_value(k + 2), edge_value(k + 4));
    endtask

    task automatic test_widest_gate();
        int      k;
        int      a;
        t_sample smp [AXES];
        wait_idle();
        write_gate(GATE_W'(32'h4000_0000));
        for (k = 0; k < 140; k++) begin
            for (a = 0; a < AXES; a++) begin
                if ($urandom_range(0, 7) == 0)
                    smp[a] = rand_sample();
                else
                    smp[a] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
            send_sample(smp[0], smp[1], smp[2]);
        end
    endtask

    task automatic test_zero_gate();
        int      k;
        int      a;
        t_sample level [AXES];
        wait_idle();
        write_gate('0);
        for (a = 0; a < AXES; a++)
            level[a] = rand_sample();
        for (k = 0; k < 140; k++)
            send_sample(level[0], level[1], level[2]);
        send_sample(level[0] + 16'sd200, level[1], level[2]);
        for (k = 0; k < 10; k++)
            send_sample(level[0], level[1], level[2]);
    endtask

    task automatic test_gate_windows();
        int phase;
        int k;
        int a;
        int seg_len;
        int amp;
        int bias [AXES];
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase % 3)
                0:       write_gate(GATE_RESET);
                1:       write_gate(GATE_W'($urandom_range(0, 20000)));
                default: write_gate(GATE_W'($urandom_range(0, 32'h4000_0000)));
            endcase
            idle_en = (phase != 2);
            for (a = 0; a < AXES; a++)
                bias[a] = int'($urandom_range(0, 65535)) - 32768;
            k = 0;
            while (k < 100) begin
                seg_len = $urandom_range(40, 160);
                amp     = $urandom_range(0, 150);
                if ($urandom_range(0, 3) == 0) begin
                    for (a = 0; a < AXES; a++)
                        bias[a] = int'($urandom_range(0, 65535)) - 32768;
                end
                repeat (seg_len) begin
                    if ($urandom_range(0, 39) == 0)
                        send_sample(rand_sample(), rand_sample(), rand_sample());
                    else
                        send_sample(near(bias[0], amp), near(bias[1], amp),
                                    near(bias[2], amp));
                    k++;
                end
            end
        end
        idle_en = 1'b1;
    endtask

    task automatic test_output_stall();
        int k;
        int a;
        int bias [AXES];
        wait_idle();
        write_gate(GATE_RESET);
        idle_en = 1'b0;
        for (a = 0; a < AXES; a++)
            bias[a] = int'($urandom_range(0, 60000)) - 30000;
        @(negedge i_clk);
        rx_hold = 250;
        @(posedge i_clk);
        for (k = 0; k < 120; k++)
            send_sample(near(bias[0], 40), near(bias[1], 40), near(bias[2], 40));
        wait_idle();
        for (k = 0; k < 80; k++)
            send_sample(near(bias[0], 60), near(bias[1], 60), near(bias[2], 60));
        idle_en = 1'b1;
    endtask

    initial begin : run
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_filling_extremes();
        test_widest_gate();
        test_zero_gate();
        test_gate_windows();
        test_output_stall();
        wait_idle();
        if (n_errors == 0 && pending_stats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/gbvg_pkg.sv
src/gbvg_sample_store.sv
src/gyro_bias_window_variance_gate.sv
dv/gyro_bias_window_variance_gate_tb.sv
